// ===== hdl/evm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evm_pkg
// Types, widths and codes shared by the vote margin block.
// ----------------------------------------------------------------------------
package evm_pkg;

  localparam int POINT_W        = 10;
  localparam int CAT_W          = 4;
  localparam int WEIGHT_W       = 16;
  localparam int ACC_W          = 32;
  localparam int NCAT_W         = 5;
  localparam int MARGIN_W       = 17;
  localparam int MAX_CATEGORIES = 1 << CAT_W;
  localparam int TABLE_DEPTH    = (1 << POINT_W) * MAX_CATEGORIES;
  localparam int ADDR_W         = POINT_W + CAT_W;
  localparam int TOTAL_W        = ACC_W + CAT_W;
  localparam int STEP_W         = $clog2(MARGIN_W);
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [MARGIN_W-1:0] ONE_FIXED = MARGIN_W'(1 << (MARGIN_W - 1));
  localparam logic [NCAT_W-1:0]   NCAT_MAX  = NCAT_W'(MAX_CATEGORIES);
  localparam logic [NCAT_W-1:0]   NCAT_RST  = NCAT_W'(2);

  localparam logic KIND_VOTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic REG_NUM_CATEGORIES = 1'b0;

  typedef struct packed {
    logic                kind;
    logic [POINT_W-1:0]  point;
    logic [CAT_W-1:0]    category;
    logic [WEIGHT_W-1:0] weight;
  } in_word_t;

  typedef struct packed {
    logic [POINT_W-1:0]  point_out;
    logic [MARGIN_W-1:0] margin;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// ===== hdl/evm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// Reading the address being written returns the old contents.
// ----------------------------------------------------------------------------
module evm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/evm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evm_div
// Restoring divider, one quotient bit per cycle.
// Gives floor(dividend * 2^16 / divisor) for dividend <= divisor.
// ----------------------------------------------------------------------------
module evm_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [evm_pkg::ACC_W-1:0]    dividend,
  input  wire logic [evm_pkg::TOTAL_W-1:0]  divisor,
  output      evm_pkg::div_sts_t            sts,
  output      logic [evm_pkg::MARGIN_W-1:0] quotient
);

  import evm_pkg::*;

  logic [TOTAL_W:0]   rem;
  logic [TOTAL_W-1:0] dvs;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;
  logic [TOTAL_W:0]   diff;
  logic               ge;

  assign diff = rem - {1'b0, dvs};
  assign ge   = rem >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= (TOTAL_W + 1)'(dividend);
      dvs      <= divisor;
      step     <= STEP_W'(MARGIN_W - 1);
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? {diff[TOTAL_W-1:0], 1'b0} : {rem[TOTAL_W-1:0], 1'b0};
      quotient <= {quotient[MARGIN_W-2:0], ge};
      step     <= step - 1'b1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule
`default_nettype wire

// ===== hdl/ensemble_vote_margin_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ensemble_vote_margin_top
// Weighted vote accumulator with margin readout and row clear.
// Vote word: RAM read, then saturating add and write back. Readout word:
// 16-entry row scan and clear, then a 17-step divide unless the row is empty
// or one category is in use. One word in flight; the output register holds a
// result while the next word is taken. Reset clears the table, input stalled.
// ----------------------------------------------------------------------------
module ensemble_vote_margin_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire evm_pkg::in_word_t           in_data,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      evm_pkg::out_word_t          out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [evm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [evm_pkg::PDATA_W-1:0] pwdata,
  output      logic [evm_pkg::PDATA_W-1:0] prdata,
  output      logic                        pready
);

  import evm_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_VWR  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_LAST = 3'd4;
  localparam logic [2:0] ST_EVAL = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]          state;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [CAT_W-1:0]    scan_cnt;
  logic [NCAT_W-1:0]   num_categories;
  logic [NCAT_W-1:0]   ncat;

  logic [POINT_W-1:0]  pt;
  logic [CAT_W-1:0]    cat;
  logic [WEIGHT_W-1:0] wt;

  logic                rd_valid;
  logic [CAT_W-1:0]    rd_idx;
  logic [TOTAL_W-1:0]  total;
  logic [ACC_W-1:0]    top;
  logic [ACC_W-1:0]    second;
  logic [MARGIN_W-1:0] margin;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ACC_W-1:0]    wdata;
  logic [ADDR_W-1:0]   raddr;
  logic [ACC_W-1:0]    rdata;
  logic [ACC_W:0]      sum;

  logic                in_acc;
  logic                out_free;
  logic                div_start;
  div_sts_t            div_sts;
  logic [MARGIN_W-1:0] quotient;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_NUM_CATEGORIES) ?
                  PDATA_W'(num_categories) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_categories <= NCAT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_NUM_CATEGORIES) begin
      num_categories <= pwdata[NCAT_W-1:0];
    end
  end

  assign ncat = (num_categories > NCAT_MAX) ? NCAT_MAX : num_categories;

  // handshake
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // table
  assign sum = {1'b0, rdata} + (ACC_W + 1)'(wt);

  always_comb begin
    we    = 1'b0;
    waddr = {pt, scan_cnt};
    wdata = '0;
    raddr = {pt, scan_cnt};
    case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      ST_IDLE: begin
        raddr = {in_data.point, in_data.category};
      end
      ST_VWR: begin
        we    = 1'b1;
        waddr = {pt, cat};
        wdata = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      end
      ST_SCAN: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  evm_ram #(
    .WIDTH (ACC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign div_start = (state == ST_EVAL) && (total != '0) && (ncat != NCAT_W'(1));

  evm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (top - second),
    .divisor  (total),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      scan_cnt  <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.kind == KIND_READ) begin
              state    <= ST_SCAN;
              scan_cnt <= '0;
            end else if ({1'b0, in_data.category} < ncat) begin
              state <= ST_VWR;
            end
          end
        end
        ST_VWR: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == '1) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= div_start ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_sts.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt  <= in_data.point;
      cat <= in_data.category;
      wt  <= in_data.weight;
    end
    if (in_acc && in_data.kind == KIND_READ) begin
      total  <= '0;
      top    <= '0;
      second <= '0;
    end else if (rd_valid && {1'b0, rd_idx} < ncat) begin
      total <= total + TOTAL_W'(rdata);
      if (rdata > top) begin
        second <= top;
        top    <= rdata;
      end else if (rdata > second) begin
        second <= rdata;
      end
    end
    rd_idx <= scan_cnt;
    if (state == ST_EVAL) begin
      if (total == '0) begin
        margin <= '0;
      end else begin
        margin <= ONE_FIXED;
      end
    end else if (state == ST_DIV && div_sts.done) begin
      margin <= quotient;
    end
    if (state == ST_DONE && out_free) begin
      out_data.point_out <= pt;
      out_data.margin    <= margin;
    end
  end

  // checks
  a_vote_one_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_VWR |=> state == ST_IDLE)
    else $error("vote write-back did not return to idle");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_cnt == '1) |=> state == ST_LAST)
    else $error("row scan did not end after the last entry");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (total != '0 && top >= second))
    else $error("divider started on an empty row");

  a_margin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.margin <= ONE_FIXED)
    else $error("margin above one");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the vote margin block: directed words with hand-computed margins for
// most readouts, then random vote sequences and readouts under several category
// counts; other readouts are scored against a vote table model. Sender bursts
// and receiver stalls are random throughout.
// ----------------------------------------------------------------------------
module tb_top;
  import evm_pkg::*;

  localparam int QUIET_LIMIT  = 80000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_WORDS  = 175;
  localparam logic [PADDR_W-1:0] CAT_ADDR = PADDR_W'(4 * int'(REG_NUM_CATEGORIES));

  typedef enum logic {ROW_WORD, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t             op;
    in_word_t            w;
    logic [NCAT_W-1:0]   ncat;
    bit                  typed;
    logic [MARGIN_W-1:0] margin;
  } plan_row_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  in_word_t           in_data   = '0;
  logic               out_stall = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic               in_stall;
  logic               out_valid;
  out_word_t          out_data;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [ACC_W-1:0]  tally [1 << POINT_W][MAX_CATEGORIES];
  logic [NCAT_W-1:0] cat_cfg = NCAT_RST;
  out_word_t         margin_queue [$];
  out_word_t         want;
  plan_row_t         plan [$];
  int                bad_words    = 0;
  int                quiet_cycles = 0;
  int                burst_left   = 0;
  int                stall_left   = 0;
  int                stall_mode   = 0;

  ensemble_vote_margin_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (tally[p, c]) tally[p][c] = '0;
  end

  function automatic in_word_t word(input int k, input int p, input int c, input int wt);
    in_word_t r;
    r.kind     = k[0];
    r.point    = POINT_W'(p);
    r.category = CAT_W'(c);
    r.weight   = WEIGHT_W'(wt);
    return r;
  endfunction

  function automatic int cats_used();
    return (cat_cfg > NCAT_MAX) ? MAX_CATEGORIES : int'(cat_cfg);
  endfunction

  function automatic logic [MARGIN_W-1:0] row_margin(input logic [POINT_W-1:0] p,
                                                     input int n);
    logic [63:0]      total;
    logic [63:0]      q;
    logic [ACC_W-1:0] top;
    logic [ACC_W-1:0] runner;
    logic [ACC_W-1:0] v;
    total  = '0;
    top    = '0;
    runner = '0;
    for (int c = 0; c < n; c++) begin
      v     = tally[p][c];
      total = total + 64'(v);
      if (v > top) begin
        runner = top;
        top    = v;
      end else if (v > runner) begin
        runner = v;
      end
    end
    if (total == 0) return '0;
    if (n == 1) return ONE_FIXED;
    q = {16'b0, top - runner, 16'b0} / total;
    return q[MARGIN_W-1:0];
  endfunction

  // point is 10 bits wide, so it is always inside the table
  task automatic tally_word(input in_word_t w, output bit has, output out_word_t res);
    int         n;
    logic [32:0] sum;
    n   = cats_used();
    has = 1'b0;
    res = '0;
    if (w.kind == KIND_VOTE) begin
      if (int'(w.category) < n) begin
        sum = {1'b0, tally[w.point][w.category]} + 33'(w.weight);
        tally[w.point][w.category] = sum[32] ? '1 : sum[ACC_W-1:0];
      end
    end else begin
      has           = 1'b1;
      res.point_out = w.point;
      res.margin    = row_margin(w.point, n);
      for (int c = 0; c < MAX_CATEGORIES; c++) tally[w.point][c] = '0;
    end
  endtask

  task automatic flag(input string msg);
    if (bad_words < 10) $display("%s", msg);
    bad_words++;
  endtask

  task automatic send(input in_word_t w, input bit typed = 1'b0,
                      input logic [MARGIN_W-1:0] m = '0);
    int        gap;
    bit        has;
    out_word_t res;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    tally_word(w, has, res);
    if (has) begin
      if (typed) res.margin = m;
      margin_queue.push_back(res);
    end
  endtask

  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (margin_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ncat(input logic [NCAT_W-1:0] n);
    logic [NCAT_W-1:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAT_ADDR;
    pwdata  <= PDATA_W'(n);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cat_cfg = n;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    back = prdata[NCAT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== n) flag($sformatf("num_categories readback: exp %0d got %0d", n, back));
  endtask

  function automatic void add_vote(input int p, input int c, input int wt);
    plan_row_t r;
    r        = '{ROW_WORD, '0, '0, 1'b0, '0};
    r.w      = word(KIND_VOTE, p, c, wt);
    plan.push_back(r);
  endfunction

  function automatic void add_read(input int p, input bit typed, input int m);
    plan_row_t r;
    r        = '{ROW_WORD, '0, '0, 1'b0, '0};
    r.w      = word(KIND_READ, p, 0, 0);
    r.typed  = typed;
    r.margin = MARGIN_W'(m);
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(input int n);
    plan_row_t r;
    r      = '{ROW_CFG, '0, '0, 1'b0, '0};
    r.ncat = NCAT_W'(n);
    plan.push_back(r);
  endfunction

  // receiver: quiet, light, heavy and periodic stall stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_left[2:0] < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (margin_queue.size() == 0) begin
        flag($sformatf("unexpected word: point %0d margin %0d",
                       out_data.point_out, out_data.margin));
      end else begin
        want = margin_queue.pop_front();
        if (out_data.point_out !== want.point_out || out_data.margin !== want.margin)
          flag($sformatf("mismatch: exp point %0d margin %0d, got point %0d margin %0d",
                         want.point_out, want.margin, out_data.point_out, out_data.margin));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [NCAT_W-1:0]  phase_ncat [8];
    logic [POINT_W-1:0] hot [4];
    logic [POINT_W-1:0] p;
    in_word_t           w;
    int                 n;
    int                 c;
    int                 wt;
    int                 live;

    phase_ncat = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd2, 5'd0, 5'd16};

    // directed words, category count starts at its reset value of 2
    add_read(0, 1'b1, 0);
    add_vote(1, 0, 16'hFFFF);
    add_vote(1, 1, 0);
    add_read(1, 1'b1, ONE_FIXED);
    add_vote(1023, 0, 100);
    add_vote(1023, 1, 100);
    add_read(1023, 1'b1, 0);
    add_vote(5, 15, 16'hFFFF);
    add_read(5, 1'b1, 0);
    add_vote(9, 0, 1);
    add_vote(9, 1, 2);
    add_read(9, 1'b0, 0);
    add_cfg(1);
    add_vote(2, 0, 5);
    add_vote(2, 1, 7);
    add_read(2, 1'b1, ONE_FIXED);
    add_cfg(0);
    add_vote(4, 0, 9);
    add_read(4, 1'b1, 0);
    add_cfg(16);
    add_vote(6, 15, 16'hFFFF);
    add_vote(6, 0, 1);
    add_read(6, 1'b0, 0);
    add_cfg(31);
    add_vote(8, 15, 10);
    add_read(8, 1'b1, ONE_FIXED);
    add_vote(10, 12, 50);
    // stale entry above the count must not count, and must be cleared
    add_cfg(2);
    add_vote(10, 0, 50);
    add_read(10, 1'b1, ONE_FIXED);
    add_cfg(16);
    add_read(10, 1'b1, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        settle();
        write_ncat(plan[i].ncat);
      end else begin
        send(plan[i].w, plan[i].typed, plan[i].margin);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_ncat(ph == 6 ? NCAT_W'($urandom_range(1, 16)) : phase_ncat[ph]);
      n = cats_used();
      foreach (hot[i]) hot[i] = POINT_W'($urandom_range(0, 1023));
      live = 0;
      while (live < PHASE_WORDS) begin
        if ($urandom_range(0, 9) < 7) begin
          p = ($urandom_range(0, 4) < 3) ? hot[$urandom_range(0, 3)]
                                         : POINT_W'($urandom_range(0, 1023));
          repeat ($urandom_range(1, 10)) begin
            c = (n > 0 && $urandom_range(0, 19) != 0) ? $urandom_range(0, n - 1)
                                                      : $urandom_range(0, 15);
            case ($urandom_range(0, 19))
              0: wt = 16'hFFFF;
              1: wt = 0;
              2: wt = $urandom_range(1, 3);
              default: wt = $urandom_range(0, 65535);
            endcase
            send(word(KIND_VOTE, p, c, wt));
            live++;
          end
          if ($urandom_range(0, 4) != 0) begin
            send(word(KIND_READ, p, $urandom_range(0, 15), $urandom_range(0, 65535)));
            live++;
          end
        end else begin
          w = word($urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 15),
                   $urandom_range(0, 65535));
          send(w);
          live++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (margin_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
